### rtl/shash_pkg.sv
// ============================================================================
// shash_pkg: shared types and constants for the SHA-256 stream hasher
// Holds the word and chain types, the round constants, the initial hash value
// and the control bundles passed between the sequencer and its datapath units.
// ============================================================================
package shash_pkg;

   typedef logic [31:0] word_type;

   // Eight-word chaining value, word 0 (first digest word) in the lowest bits.
   typedef word_type [7:0] chain_type;

   typedef logic [5:0] round_idx_type;

   localparam int ROUNDS = 64;

   localparam logic [7:0] PAD_MARK      = 8'h80;
   localparam logic [5:0] LEN_FIRST_POS = 6'd56;

   localparam chain_type INIT_CHAIN = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Controls for the block buffer and message schedule.
   typedef struct packed {
      logic       load_byte;
      logic       shift_word;
      logic [7:0] byte_val;
   } sched_ctl_type;

   // Controls for the round unit and chaining value.
   typedef struct packed {
      logic load;
      logic step;
      logic fold;
      logic reinit;
   } round_ctl_type;

   // Rotate a word right by a fixed amount.
   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

### rtl/shash_sched.sv
// ============================================================================
// shash_sched: block buffer and message schedule window
// Collects message bytes into a 512-bit shift register, then during
// compression shifts it a word at a time and appends the next schedule word.
// ============================================================================
module shash_sched (
   input  logic                      clock,
   input  shash_pkg::sched_ctl_type  ctl,
   output shash_pkg::word_type       w_cur
);
   import shash_pkg::*;

   localparam int BLOCK_BITS = 512;

   logic [BLOCK_BITS-1:0] win_ff;
   logic [BLOCK_BITS-1:0] win_in;
   word_type              w1;
   word_type              w9;
   word_type              w14;
   word_type              sig0;
   word_type              sig1;
   word_type              w_new;

   // Word i of the window (i = 0 oldest) sits at the top, one word per 32 bits.
   assign w_cur = win_ff[BLOCK_BITS-1 -: 32];
   assign w1    = win_ff[BLOCK_BITS-1-32*1 -: 32];
   assign w9    = win_ff[BLOCK_BITS-1-32*9 -: 32];
   assign w14   = win_ff[BLOCK_BITS-1-32*14 -: 32];

   // Next schedule word from the sliding sixteen-word window.
   always_comb begin
      sig0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
      sig1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
      w_new = w_cur + sig0 + w9 + sig1;
   end

   // Bytes enter at the bottom, so the first byte ends up most significant.
   always_comb begin
      win_in = win_ff;
      if (ctl.load_byte) begin
         win_in = {win_ff[BLOCK_BITS-9:0], ctl.byte_val};
      end else if (ctl.shift_word) begin
         win_in = {win_ff[BLOCK_BITS-33:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

### rtl/shash_round.sv
// ============================================================================
// shash_round: shared SHA-256 round unit and chaining value
// Holds the eight working variables, applies one compression round per
// cycle, and folds the result into the chaining value at block end.
// ============================================================================
module shash_round (
   input  logic                      clock,
   input  logic                      reset,
   input  shash_pkg::round_ctl_type  ctl,
   input  shash_pkg::round_idx_type  round_idx,
   input  shash_pkg::word_type       w_cur,
   output shash_pkg::chain_type      chain
);
   import shash_pkg::*;

   chain_type chain_ff;
   chain_type chain_in;
   chain_type work_ff;
   chain_type work_in;
   word_type  big0;
   word_type  big1;
   word_type  ch;
   word_type  maj;
   word_type  t1;
   word_type  t2;

   assign chain = chain_ff;

   // One round of the compression function.
   always_comb begin
      big1 = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
      ch   = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1   = work_ff[7] + big1 + ch + ROUND_K[round_idx] + w_cur;
      big0 = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
      maj  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
           ^ (work_ff[1] & work_ff[2]);
      t2   = big0 + maj;
   end

   // Working variables: load from the chain, or advance by one round.
   always_comb begin
      work_in = work_ff;
      if (ctl.load) begin
         work_in = chain_ff;
      end else if (ctl.step) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
   end

   // Chaining value: add the working variables at block end, or restart.
   always_comb begin
      chain_in = chain_ff;
      if (ctl.reinit) begin
         chain_in = INIT_CHAIN;
      end else if (ctl.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_CHAIN;
      end else begin
         chain_ff <= chain_in;
      end
   end

endmodule

### rtl/sha256_stream_hasher_top.sv
// ============================================================================
// sha256_stream_hasher_top: byte-stream SHA-256 hasher
// Takes a message one byte per beat, pads it and returns the eight-word
// digest as eight beats, then starts over for the next message.
// ============================================================================
//
//  Channel  Dir  Beat contents                        Marker
//  -------  ---  -----------------------------------  --------------------------
//  req_     in   tdata: message byte; tuser: has_byte tlast: end of message
//  rsp_     out  tdata: digest word, word index       tlast: eighth digest word
//
// A byte beat is taken while the hasher is idle; the 64th byte of a block
// starts a compression (64 rounds on the single round unit, one fold),
// during which no new byte is taken. The end of a message adds padding bytes
// up to the block end, one or two compressions, and eight digest beats.
// req_tready is low meanwhile; a stalled digest beat holds until taken.
// Reset is synchronous, with no clearing pass.
//
module sha256_stream_hasher_top #(
   parameter int LENGTH_COUNT_BITS = 61
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // end_of_msg
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zero above
   output logic        rsp_tlast    // last_word
);
   import shash_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PAD  = 3'd1;
   localparam logic [2:0] S_COMP = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [LENGTH_COUNT_BITS-1:0] count_ff, count_in;
   logic [5:0]                   pos_ff, pos_in;
   round_idx_type                round_ff, round_in;
   logic [2:0]                   out_idx_ff, out_idx_in;
   logic                         pad_mode_ff, pad_mode_in;
   logic                         mark_ff, mark_in;
   logic                         len_ok_ff, len_ok_in;
   logic                         final_ff, final_in;

   sched_ctl_type                sctl;
   round_ctl_type                rctl;
   word_type                     w_cur;
   chain_type                    chain;
   logic [63:0]                  len_bits;
   logic [7:0]                   len_byte;
   logic                         req_beat;

   assign req_beat = req_tvalid && req_tready;

   // Message length in bits, big-endian byte picked by block position.
   assign len_bits = 64'(count_ff) << 3;
   assign len_byte = 8'(len_bits >> {~pos_ff[2:0], 3'b000});

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      round_in    = round_ff;
      out_idx_in  = out_idx_ff;
      pad_mode_in = pad_mode_ff;
      mark_in     = mark_ff;
      len_ok_in   = len_ok_ff;
      final_in    = final_ff;
      sctl        = '0;
      rctl        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               if (req_tuser) begin
                  sctl.load_byte = 1'b1;
                  sctl.byte_val  = req_tdata;
                  count_in       = count_ff + LENGTH_COUNT_BITS'(1);
                  pos_in         = pos_ff + 6'd1;
               end
               if (req_tuser && (&pos_ff)) begin
                  state_in    = S_COMP;
                  rctl.load   = 1'b1;
                  round_in    = '0;
                  pad_mode_in = req_tlast;
                  mark_in     = req_tlast;
                  len_ok_in   = 1'b0;
                  final_in    = 1'b0;
               end else if (req_tlast) begin
                  state_in    = S_PAD;
                  pad_mode_in = 1'b1;
                  mark_in     = 1'b1;
                  len_ok_in   = 1'b0;
                  final_in    = 1'b0;
               end
            end
         end
         S_PAD: begin
            // Marker byte first, then zeros, with the length in the last block.
            sctl.load_byte = 1'b1;
            if (mark_ff) begin
               sctl.byte_val = PAD_MARK;
               len_ok_in     = (pos_ff < LEN_FIRST_POS);
            end else if (len_ok_ff && (pos_ff >= LEN_FIRST_POS)) begin
               sctl.byte_val = len_byte;
            end else begin
               sctl.byte_val = '0;
            end
            mark_in = 1'b0;
            pos_in  = pos_ff + 6'd1;
            if (&pos_ff) begin
               state_in  = S_COMP;
               rctl.load = 1'b1;
               round_in  = '0;
               final_in  = len_ok_ff && !mark_ff;
            end
         end
         S_COMP: begin
            rctl.step       = 1'b1;
            sctl.shift_word = 1'b1;
            round_in        = round_ff + 6'd1;
            if (&round_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            rctl.fold = 1'b1;
            if (final_ff) begin
               state_in   = S_OUT;
               out_idx_in = '0;
            end else if (pad_mode_ff) begin
               // A fresh block after the marker always has room for the length.
               state_in  = S_PAD;
               len_ok_in = 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (&out_idx_ff) begin
                  rctl.reinit = 1'b1;
                  count_in    = '0;
                  pos_in      = '0;
                  pad_mode_in = 1'b0;
                  mark_in     = 1'b0;
                  final_in    = 1'b0;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         pos_ff      <= '0;
         round_ff    <= '0;
         out_idx_ff  <= '0;
         pad_mode_ff <= 1'b0;
         mark_ff     <= 1'b0;
         len_ok_ff   <= 1'b0;
         final_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pos_ff      <= pos_in;
         round_ff    <= round_in;
         out_idx_ff  <= out_idx_in;
         pad_mode_ff <= pad_mode_in;
         mark_ff     <= mark_in;
         len_ok_ff   <= len_ok_in;
         final_ff    <= final_in;
      end
   end

   // Block buffer and schedule.
   shash_sched u_sched (
      .clock (clock),
      .ctl   (sctl),
      .w_cur (w_cur)
   );

   // Round unit and chaining value.
   shash_round u_round (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rctl),
      .round_idx (round_ff),
      .w_cur     (w_cur),
      .chain     (chain)
   );

   // Handshakes and digest beats.
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {5'b00000, out_idx_ff, chain[out_idx_ff]};
   assign rsp_tlast  = &out_idx_ff;

`ifndef SYNTH
   // Input and output sides are never open at the same time.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while digest beat pending");

   // After the last digest beat the hasher is back at its start state.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=>
         (req_tready && count_ff == '0 && pos_ff == '0))
      else $error("hasher not restarted after digest");

   // Compression never ends before the last round.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMP && !(&round_ff)) |=> (state_ff == S_COMP))
      else $error("compression cut short");

   // Digest output only follows a fold of the final block.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == S_FIN && $past(final_ff)))
      else $error("digest output without final block");
`endif

endmodule
